@@ rtl/core/two_wire_pot_wiper_master_unit_assert.svh @@
// assertion helpers for the pot wiper bus master
`ifndef TWO_WIRE_POT_WIPER_MASTER_UNIT_ASSERT_SVH
`define TWO_WIRE_POT_WIPER_MASTER_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TWPW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("twpw assertion failed");

// next-cycle implication, checked out of reset
`define TWPW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("twpw assertion failed");

`endif

@@ rtl/core/twpw_pkg.sv @@
`default_nettype none
package twpw_pkg;

  // ticks each bus phase is held
  localparam int PHASE_TICKS = 1;
  localparam int TICK_W      = 10;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK  = 2'd1;
  localparam logic [1:0] ST_INSTR_NACK = 2'd2;
  localparam logic [1:0] ST_DATA_NACK  = 2'd3;

  localparam logic [7:0] SLAVE_RESET = 8'h50;
  localparam logic [7:0] INSTR_WR    = 8'hA0;
  localparam logic [7:0] INSTR_RD    = 8'h90;

  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_ST_A  = 5'd1;
  localparam logic [4:0] PH_ST_B  = 5'd2;
  localparam logic [4:0] PH_ST_C  = 5'd3;
  localparam logic [4:0] PH_W_SET = 5'd4;
  localparam logic [4:0] PH_W_HI  = 5'd5;
  localparam logic [4:0] PH_W_LO  = 5'd6;
  localparam logic [4:0] PH_A_REL = 5'd7;
  localparam logic [4:0] PH_A_HI  = 5'd8;
  localparam logic [4:0] PH_A_LO  = 5'd9;
  localparam logic [4:0] PH_R_REL = 5'd10;
  localparam logic [4:0] PH_R_HI  = 5'd11;
  localparam logic [4:0] PH_R_LO  = 5'd12;
  localparam logic [4:0] PH_N_SET = 5'd13;
  localparam logic [4:0] PH_N_HI  = 5'd14;
  localparam logic [4:0] PH_N_LO  = 5'd15;
  localparam logic [4:0] PH_P_A   = 5'd16;
  localparam logic [4:0] PH_P_B   = 5'd17;
  localparam logic [4:0] PH_P_C   = 5'd18;

  typedef struct packed {
    logic [1:0] op;
    logic [1:0] pot;
    logic [7:0] value;
    logic       sda_in;
  } twpw_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] read_data;
  } twpw_res_t;

  // clock level of each bus phase
  function automatic logic scl_of(input logic [4:0] ph);
    logic lvl;
    case (ph)
      PH_IDLE, PH_ST_A, PH_ST_B, PH_W_HI, PH_A_HI,
      PH_R_HI, PH_N_HI, PH_P_B, PH_P_C: lvl = 1'b1;
      default:                          lvl = 1'b0;
    endcase
    return lvl;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/twpw_seq.sv @@
`default_nettype none
module twpw_seq import twpw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire twpw_item_t item,
  input  wire logic [7:0] slave_byte,
  output twpw_res_t       res
);

  logic [4:0]        phase_r, phase_nxt;
  logic [3:0]        bit_r, bit_nxt;
  logic [7:0]        shift_r, shift_nxt;
  logic [1:0]        byte_idx_r, byte_idx_nxt;
  logic              is_read_r, is_read_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic [TICK_W-1:0] tick_r, tick_nxt;
  logic [7:0]        instr_r, instr_nxt;
  logic [7:0]        value_r, value_nxt;
  logic              nack_r, nack_nxt;
  logic [1:0]        status_r, status_nxt;

  logic              start;
  logic [4:0]        ph;
  logic [TICK_W-1:0] tick_base;
  logic              phase_end;
  logic [3:0]        bit_inc;
  logic              done;
  logic [2:0]        nack_code;

  always_comb begin
    phase_nxt    = phase_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    byte_idx_nxt = byte_idx_r;
    is_read_nxt  = is_read_r;
    hold_nxt     = hold_r;
    tick_nxt     = tick_r;
    instr_nxt    = instr_r;
    value_nxt    = value_r;
    nack_nxt     = nack_r;
    status_nxt   = status_r;
    done         = 1'b0;

    start = (phase_r == PH_IDLE) && (item.op == OP_WRITE || item.op == OP_READ);
    tick_base = start ? '0 : tick_r;
    ph = start ? PH_ST_A : phase_r;
    if (ph > PH_P_C) begin
      ph = PH_IDLE;
    end
    phase_end = ({1'b0, tick_base} + (TICK_W+1)'(1)) >= (TICK_W+1)'(PHASE_TICKS);
    bit_inc = bit_r + 4'd1;
    nack_code = {1'b0, byte_idx_r} + 3'd1;

    if (start) begin
      is_read_nxt  = (item.op == OP_READ);
      instr_nxt    = ((item.op == OP_READ) ? INSTR_RD : INSTR_WR) + {4'd0, item.pot, 2'b00};
      value_nxt    = item.value;
      byte_idx_nxt = 2'd0;
      nack_nxt     = 1'b0;
    end
    phase_nxt = ph;
    tick_nxt  = tick_base;

    if (ph != PH_IDLE) begin
      if (phase_end) begin
        tick_nxt = '0;
        case (ph)
          PH_ST_A:  phase_nxt = PH_ST_B;
          PH_ST_B:  phase_nxt = PH_ST_C;
          PH_ST_C: begin
            shift_nxt    = slave_byte;
            bit_nxt      = 4'd0;
            byte_idx_nxt = 2'd0;
            phase_nxt    = PH_W_SET;
          end
          PH_W_SET: phase_nxt = PH_W_HI;
          PH_W_HI:  phase_nxt = PH_W_LO;
          PH_W_LO: begin
            shift_nxt = {shift_r[6:0], 1'b0};
            bit_nxt   = bit_inc;
            phase_nxt = (bit_inc >= 4'd8) ? PH_A_REL : PH_W_SET;
          end
          PH_A_REL: phase_nxt = PH_A_HI;
          PH_A_HI: begin
            nack_nxt  = item.sda_in;
            phase_nxt = PH_A_LO;
          end
          PH_A_LO: begin
            if (nack_r) begin
              status_nxt = (nack_code > 3'd3) ? ST_DATA_NACK : nack_code[1:0];
              done       = 1'b1;
              phase_nxt  = PH_IDLE;
            end else if (byte_idx_r == 2'd0) begin
              shift_nxt    = instr_r;
              bit_nxt      = 4'd0;
              phase_nxt    = PH_W_SET;
              byte_idx_nxt = 2'd1;
            end else if (byte_idx_r == 2'd1 && is_read_r) begin
              shift_nxt = 8'd0;
              bit_nxt   = 4'd0;
              phase_nxt = PH_R_REL;
            end else if (byte_idx_r == 2'd1) begin
              shift_nxt    = value_r;
              bit_nxt      = 4'd0;
              phase_nxt    = PH_W_SET;
              byte_idx_nxt = 2'd2;
            end else begin
              phase_nxt = PH_P_A;
            end
          end
          PH_R_REL: phase_nxt = PH_R_HI;
          PH_R_HI: begin
            shift_nxt = {shift_r[6:0], item.sda_in};
            phase_nxt = PH_R_LO;
          end
          PH_R_LO: begin
            bit_nxt   = bit_inc;
            phase_nxt = (bit_inc >= 4'd8) ? PH_N_SET : PH_R_HI;
          end
          PH_N_SET: phase_nxt = PH_N_HI;
          PH_N_HI:  phase_nxt = PH_N_LO;
          PH_N_LO: begin
            hold_nxt  = shift_r;
            phase_nxt = PH_P_A;
          end
          PH_P_A:   phase_nxt = PH_P_B;
          PH_P_B:   phase_nxt = PH_P_C;
          default: begin
            status_nxt = ST_OK;
            done       = 1'b1;
            phase_nxt  = PH_IDLE;
          end
        endcase
      end else begin
        tick_nxt = tick_base + TICK_W'(1);
      end
    end

    res.scl = scl_of(ph);
    case (ph)
      PH_ST_B, PH_ST_C, PH_P_A, PH_P_B: res.sda_out = 1'b0;
      PH_W_SET, PH_W_HI, PH_W_LO:       res.sda_out = shift_r[7];
      default:                          res.sda_out = 1'b1;
    endcase
    res.busy_res  = (ph != PH_IDLE);
    res.done_res  = done;
    res.status    = status_nxt;
    res.read_data = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_r      <= '0;
      shift_r    <= '0;
      byte_idx_r <= '0;
      is_read_r  <= 1'b0;
      hold_r     <= '0;
      tick_r     <= '0;
      instr_r    <= '0;
      value_r    <= '0;
      nack_r     <= 1'b0;
      status_r   <= ST_OK;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      byte_idx_r <= byte_idx_nxt;
      is_read_r  <= is_read_nxt;
      hold_r     <= hold_nxt;
      tick_r     <= tick_nxt;
      instr_r    <= instr_nxt;
      value_r    <= value_nxt;
      nack_r     <= nack_nxt;
      status_r   <= status_nxt;
    end
  end

`include "two_wire_pot_wiper_master_unit_assert.svh"

  `TWPW_ASSERT_NOW(a_phase_range, 1'b1, phase_r <= PH_P_C)
  `TWPW_ASSERT_NOW(a_idle_released, step && !res.busy_res, res.scl && res.sda_out)
  `TWPW_ASSERT_NEXT(a_done_goes_idle, step && res.done_res, phase_r == PH_IDLE)

endmodule
`default_nettype wire

@@ rtl/core/two_wire_pot_wiper_master_unit.sv @@
// two-wire bus master for a quad digital potentiometer, one bus phase per beat
//
// input channel: every beat on in_* is one bus tick; in_op selects a plain tick,
// a wiper write or a wiper read, in_sda_in is the sampled data line level.
// a command given while a transfer runs is treated as a plain tick.
// result channel: exactly one beat per input beat, in order, carrying the
// scl/sda levels to drive for that tick plus busy, done, status and read data.
// cfg_we/cfg_wdata write the slave address byte; write it only while idle.
// a taken beat is registered in the input stage, and its result then in the result register that drives out_*.
// throughput: one beat per cycle while out_stall is low; the whole phase sequencer step is a single
// combinational pass between the input stage and the result register.
// a result register parts the two sides, so the input keeps taking beats while
// a result waits; a stalled result holds, and in_stall rises once the input
// stage is full behind it.
// reset (rst_n low at a clock edge): bus idle and released, status ok,
// read data zero, slave byte 0x50, both pipeline stages empty.
`default_nettype none
module two_wire_pot_wiper_master_unit import twpw_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_op,
  input  wire logic [1:0] in_pot,
  input  wire logic [7:0] in_value,
  input  wire logic       in_sda_in,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_scl,
  output logic            out_sda_out,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic [1:0]      out_status,
  output logic [7:0]      out_read_data
);

  logic [7:0] slave_byte_r;

  // input stage
  logic       s1_valid_r, s1_valid_nxt;
  twpw_item_t s1_item_r;
  logic       in_acc;
  logic       s1_adv;

  // result stage
  logic       out_valid_r, out_valid_nxt;
  twpw_res_t  out_res_r;
  twpw_res_t  seq_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_byte_r <= SLAVE_RESET;
    end else if (cfg_we) begin
      slave_byte_r <= cfg_wdata;
    end
  end

  // the input stage moves on when the result register is free or draining
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.op     <= in_op;
      s1_item_r.pot    <= in_pot;
      s1_item_r.value  <= in_value;
      s1_item_r.sda_in <= in_sda_in;
    end
    if (s1_adv) begin
      out_res_r <= seq_res;
    end
  end

  // phase sequencer: steps once per beat leaving the input stage
  twpw_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .item       (s1_item_r),
    .slave_byte (slave_byte_r),
    .res        (seq_res)
  );

  assign out_valid     = out_valid_r;
  assign out_scl       = out_res_r.scl;
  assign out_sda_out   = out_res_r.sda_out;
  assign out_busy_res  = out_res_r.busy_res;
  assign out_done_res  = out_res_r.done_res;
  assign out_status    = out_res_r.status;
  assign out_read_data = out_res_r.read_data;

`include "two_wire_pot_wiper_master_unit_assert.svh"

  // a full input stage behind a stalled result must not be dropped
  `TWPW_ASSERT_NEXT(a_s1_holds, s1_valid_r && out_valid_r && out_stall, s1_valid_r)
  // a stage that advances always fills the result register
  `TWPW_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_r)
  // the input only stalls with a beat parked in the input stage
  `TWPW_ASSERT_NOW(a_stall_needs_full, in_stall, s1_valid_r)

endmodule
`default_nettype wire

@@ tb/two_wire_pot_wiper_master_unit_tb.sv @@
`timescale 1ns / 1ps

module two_wire_pot_wiper_master_unit_tb import twpw_pkg::*; ();

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // configuration port
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;

  // input channel
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_op = OP_TICK;
  logic [1:0] in_pot = 2'd0;
  logic [7:0] in_value = 8'h00;
  logic       in_sda_in = 1'b1;

  // result channel
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl;
  logic       out_sda_out;
  logic       out_busy_res;
  logic       out_done_res;
  logic [1:0] out_status;
  logic [7:0] out_read_data;

  two_wire_pot_wiper_master_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_pot       (in_pot),
    .in_value     (in_value),
    .in_sda_in    (in_sda_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_scl      (out_scl),
    .out_sda_out  (out_sda_out),
    .out_busy_res (out_busy_res),
    .out_done_res (out_done_res),
    .out_status   (out_status),
    .out_read_data(out_read_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5000000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the bus sequencer, advanced once per accepted input beat
  // ---------------------------------------------------------------------------
  logic [4:0] bus_ph;
  logic [3:0] bit_cnt;
  logic [7:0] shreg;
  logic [1:0] byte_idx;
  logic       rd_mode;
  logic [7:0] rd_hold;
  int         tick_cnt;
  logic [7:0] instr_byte;
  logic [7:0] wr_value;
  logic       nack_flag;
  logic [1:0] last_st;
  logic [7:0] slave_addr;

  // expected result beats, oldest first
  twpw_res_t tick_results_q[$];

  int mismatch_count = 0;
  int beats_sent = 0;
  int beats_checked = 0;

  // idling knobs, flipped by the tests
  bit gaps_on = 1'b0;
  bit stall_on = 1'b0;
  int hold_request = 0;

  task automatic reset_shadow();
    bus_ph     = PH_IDLE;
    bit_cnt    = '0;
    shreg      = '0;
    byte_idx   = '0;
    rd_mode    = 1'b0;
    rd_hold    = '0;
    tick_cnt   = 0;
    instr_byte = '0;
    wr_value   = '0;
    nack_flag  = 1'b0;
    last_st    = ST_OK;
    slave_addr = SLAVE_RESET;
  endtask

  // one bus tick: levels come from the phase before it advances
  function automatic twpw_res_t predict_bus_tick(input twpw_item_t it);
    twpw_res_t  r;
    logic [4:0] ph;
    logic       done;
    done = 1'b0;

    // a command only starts from idle; otherwise it is a plain tick
    if (bus_ph == PH_IDLE && (it.op == OP_WRITE || it.op == OP_READ)) begin
      rd_mode    = (it.op == OP_READ);
      instr_byte = (rd_mode ? INSTR_RD : INSTR_WR) + {4'd0, it.pot, 2'b00};
      wr_value   = it.value;
      byte_idx   = 2'd0;
      nack_flag  = 1'b0;
      tick_cnt   = 0;
      bus_ph     = PH_ST_A;
    end
    ph = bus_ph;

    // scl is low on setup, release and low phases, and on PH_ST_C and PH_P_A
    case (ph)
      PH_ST_C, PH_W_SET, PH_W_LO, PH_A_REL, PH_A_LO,
      PH_R_REL, PH_R_LO, PH_N_SET, PH_N_LO, PH_P_A: r.scl = 1'b0;
      default:                                      r.scl = 1'b1;
    endcase
    // sda pulled low for start and stop, msb of the byte while writing
    case (ph)
      PH_ST_B, PH_ST_C, PH_P_A, PH_P_B: r.sda_out = 1'b0;
      PH_W_SET, PH_W_HI, PH_W_LO:       r.sda_out = shreg[7];
      default:                          r.sda_out = 1'b1;
    endcase
    r.busy_res = (ph != PH_IDLE);

    if (ph != PH_IDLE) begin
      if (tick_cnt + 1 >= PHASE_TICKS) begin
        tick_cnt = 0;
        case (ph)
          PH_ST_A: bus_ph = PH_ST_B;
          PH_ST_B: bus_ph = PH_ST_C;
          PH_ST_C: begin
            shreg    = slave_addr;
            bit_cnt  = '0;
            byte_idx = 2'd0;
            bus_ph   = PH_W_SET;
          end
          PH_W_SET: bus_ph = PH_W_HI;
          PH_W_HI:  bus_ph = PH_W_LO;
          PH_W_LO: begin
            shreg   = {shreg[6:0], 1'b0};
            bit_cnt = bit_cnt + 4'd1;
            bus_ph  = (bit_cnt >= 4'd8) ? PH_A_REL : PH_W_SET;
          end
          PH_A_REL: bus_ph = PH_A_HI;
          PH_A_HI: begin
            nack_flag = it.sda_in;
            bus_ph    = PH_A_LO;
          end
          PH_A_LO: begin
            if (nack_flag) begin
              // abort with no stop, code tells which byte failed
              case (byte_idx)
                2'd0:    last_st = ST_ADDR_NACK;
                2'd1:    last_st = ST_INSTR_NACK;
                default: last_st = ST_DATA_NACK;
              endcase
              done   = 1'b1;
              bus_ph = PH_IDLE;
            end else if (byte_idx == 2'd0) begin
              shreg    = instr_byte;
              bit_cnt  = '0;
              byte_idx = 2'd1;
              bus_ph   = PH_W_SET;
            end else if (byte_idx == 2'd1 && rd_mode) begin
              shreg   = '0;
              bit_cnt = '0;
              bus_ph  = PH_R_REL;
            end else if (byte_idx == 2'd1) begin
              shreg    = wr_value;
              bit_cnt  = '0;
              byte_idx = 2'd2;
              bus_ph   = PH_W_SET;
            end else begin
              bus_ph = PH_P_A;
            end
          end
          PH_R_REL: bus_ph = PH_R_HI;
          PH_R_HI: begin
            shreg  = {shreg[6:0], it.sda_in};
            bus_ph = PH_R_LO;
          end
          PH_R_LO: begin
            bit_cnt = bit_cnt + 4'd1;
            bus_ph  = (bit_cnt >= 4'd8) ? PH_N_SET : PH_R_HI;
          end
          PH_N_SET: bus_ph = PH_N_HI;
          PH_N_HI:  bus_ph = PH_N_LO;
          PH_N_LO: begin
            rd_hold = shreg;
            bus_ph  = PH_P_A;
          end
          PH_P_A: bus_ph = PH_P_B;
          PH_P_B: bus_ph = PH_P_C;
          default: begin
            last_st = ST_OK;
            done    = 1'b1;
            bus_ph  = PH_IDLE;
          end
        endcase
      end else begin
        tick_cnt = (tick_cnt + 1) % 1024;
      end
    end

    r.done_res  = done;
    r.status    = last_st;
    r.read_data = rd_hold;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatch_count < 40)
      $display("mismatch %s: got %0h want %0h at result beat %0d", what, got, want,
               beats_checked);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) flag_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // sender side: offer one beat, hold it until taken, then maybe go quiet
  // called right after a rising edge
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] op, input logic [1:0] pot,
                           input logic [7:0] value, input logic sda);
    twpw_item_t it;
    int         gap;
    it = '{op: op, pot: pot, value: value, sda_in: sda};
    in_valid  <= 1'b1;
    in_op     <= op;
    in_pot    <= pot;
    in_value  <= value;
    in_sda_in <= sda;
    // stall seen here is the level from before this edge
    do @(posedge clk); while (in_stall);
    tick_results_q.push_back(predict_bus_tick(it));
    beats_sent++;
    if (gaps_on && $urandom_range(0, 99) < 30) begin
      // mostly short gaps, now and then a long one
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // a full command: start beat, then ticks until the shadow goes idle
  // the slave acks every byte except byte nack_at (3 = none) and returns rd_bits
  task automatic run_transfer(input logic [1:0] op, input logic [1:0] pot,
                              input logic [7:0] value, input int nack_at,
                              input logic [7:0] rd_bits, input bit busy_noise);
    logic       sda;
    logic [1:0] tick_op;
    int         bi;
    send_beat(op, pot, value, 1'($urandom_range(0, 1)));
    while (bus_ph != PH_IDLE) begin
      sda = 1'($urandom_range(0, 1));
      if (bus_ph == PH_A_HI) begin
        sda = (byte_idx == nack_at);
      end else if (bus_ph == PH_R_HI) begin
        bi  = 7 - bit_cnt;
        sda = rd_bits[bi];
      end
      // commands thrown in mid-transfer must be ignored
      tick_op = OP_TICK;
      if (busy_noise && $urandom_range(0, 9) == 0) tick_op = 2'($urandom_range(0, 3));
      send_beat(tick_op, 2'($urandom), 8'($urandom), sda);
    end
  endtask

  // sender goes quiet until every expected beat has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (tick_results_q.size() != 0) @(posedge clk);
  endtask

  // only written with the block idle and drained
  task automatic set_slave_byte(input logic [7:0] v);
    wait_results_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    slave_addr  = v;
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: check each taken result beat
  // ---------------------------------------------------------------------------
  twpw_res_t want_beat;
  twpw_res_t got_beat;
  int        hold_left = 0;
  int        stall_run = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got_beat = '{scl: out_scl, sda_out: out_sda_out, busy_res: out_busy_res,
                   done_res: out_done_res, status: out_status, read_data: out_read_data};
      if (tick_results_q.size() == 0) begin
        flag_mismatch("unexpected result beat", got_beat, 0);
      end else begin
        want_beat = tick_results_q.pop_front();
        check_field("scl", got_beat.scl, want_beat.scl);
        check_field("sda_out", got_beat.sda_out, want_beat.sda_out);
        check_field("busy_res", got_beat.busy_res, want_beat.busy_res);
        check_field("done_res", got_beat.done_res, want_beat.done_res);
        check_field("status", got_beat.status, want_beat.status);
        check_field("read_data", got_beat.read_data, want_beat.read_data);
      end
      beats_checked++;
    end
  end

  // receiver stall level: long hold-off asked by a test, counted down here, else random stall runs while stall_on
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (stall_on && $urandom_range(0, 99) < 25) begin
      stall_run = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // released bus on plain ticks, and a selector of 3 counts as a tick
  task automatic test_idle_ticks();
    send_beat(OP_TICK, 2'd0, 8'h00, 1'b0);
    send_beat(OP_TICK, 2'd3, 8'hFF, 1'b1);
    send_beat(2'd3, 2'd3, 8'hFF, 1'b0);
    send_beat(2'd3, 2'd0, 8'h00, 1'b1);
  endtask

  // full writes with every byte acked, field extremes
  task automatic test_wiper_write();
    run_transfer(OP_WRITE, 2'd3, 8'hFF, 3, 8'h00, 1'b0);
    run_transfer(OP_WRITE, 2'd0, 8'h00, 3, 8'hFF, 1'b0);
  endtask

  // reads shift in msb first and answer with a nack and a stop
  task automatic test_wiper_read();
    run_transfer(OP_READ, 2'd2, 8'h00, 3, 8'hA5, 1'b0);
    run_transfer(OP_READ, 2'd1, 8'hFF, 3, 8'h00, 1'b0);
    run_transfer(OP_READ, 2'd3, 8'h5A, 3, 8'hFF, 1'b0);
  endtask

  // every abort code; a failed read must keep the old read data
  task automatic test_nack_aborts();
    run_transfer(OP_WRITE, 2'd1, 8'h3C, 0, 8'h00, 1'b0);
    run_transfer(OP_WRITE, 2'd2, 8'hC3, 1, 8'h00, 1'b0);
    run_transfer(OP_WRITE, 2'd3, 8'h81, 2, 8'h00, 1'b0);
    run_transfer(OP_READ, 2'd0, 8'h00, 1, 8'h12, 1'b0);
    run_transfer(OP_READ, 2'd2, 8'h00, 0, 8'h34, 1'b0);
  endtask

  // commands arriving mid-transfer are plain ticks
  task automatic test_busy_commands();
    run_transfer(OP_WRITE, 2'd2, 8'h69, 3, 8'h00, 1'b1);
    run_transfer(OP_READ, 2'd1, 8'h00, 3, 8'h96, 1'b1);
  endtask

  // receiver holds off long while the sender keeps offering beats back to back
  task automatic test_backpressure();
    gaps_on      = 1'b0;
    hold_request = 300;
    run_transfer(OP_WRITE, 2'd1, 8'hA7, 3, 8'h00, 1'b0);
    run_transfer(OP_READ, 2'd2, 8'h00, 3, 8'h3E, 1'b1);
    wait_results_drained();
  endtask

  // mostly well-formed transfers with random content, some noise and aborts
  task automatic test_random_traffic(input logic [7:0] slave, input int n_beats,
                                     input bit gaps, input bit stalls);
    int         target;
    int         pick;
    int         nack_at;
    logic [1:0] op;
    set_slave_byte(slave);
    gaps_on  = gaps;
    stall_on = stalls;
    target   = beats_sent + n_beats;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        op      = ($urandom_range(0, 1) != 0) ? OP_READ : OP_WRITE;
        nack_at = ($urandom_range(0, 99) < 70) ? 3 : $urandom_range(0, 2);
        run_transfer(op, 2'($urandom), 8'($urandom), nack_at, 8'($urandom),
                     $urandom_range(0, 2) == 0);
      end else if (pick < 93) begin
        send_beat(OP_TICK, 2'($urandom), 8'($urandom), 1'($urandom));
      end else begin
        send_beat(2'd3, 2'($urandom), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    reset_shadow();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset slave byte, no idling for the first three tests
    test_idle_ticks();
    test_wiper_write();
    test_wiper_read();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    test_nack_aborts();
    test_busy_commands();
    test_backpressure();

    // random phases across slave byte extremes and idling styles
    test_random_traffic(8'h00, 40, 1'b1, 1'b1);
    test_random_traffic(8'hFF, 40, 1'b0, 1'b0);
    test_random_traffic(8'($urandom), 40, 1'b1, 1'b0);
    test_random_traffic(SLAVE_RESET, 40, 1'b0, 1'b1);

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (tick_results_q.size() != 0)
      flag_mismatch("results never arrived", tick_results_q.size(), 0);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ two_wire_pot_wiper_master_unit.f @@
+incdir+rtl/core
rtl/core/twpw_pkg.sv
rtl/core/twpw_seq.sv
rtl/core/two_wire_pot_wiper_master_unit.sv
tb/two_wire_pot_wiper_master_unit_tb.sv
